[hdl/ifd_pkg.sv]
package ifd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FOLDS   = 10;

  // Configuration register widths and indexes.
  localparam int DRV_GAIN_W = 13;
  localparam int THR_W      = 16;
  localparam int LIMIT_W    = 4;
  localparam int WET_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN      = 3'd4;

  localparam logic [DRV_GAIN_W-1:0] DRIVE_GAIN_RST    = 13'd2688;
  localparam logic [THR_W-1:0]      FOLD_THRESHOLD_RST = 16'd18022;
  localparam logic [LIMIT_W-1:0]    FOLD_LIMIT_RST    = 4'd3;
  localparam logic [WET_W-1:0]      WET_MIX_RST       = 16'd32768;
  localparam logic [GAIN_W-1:0]     OUT_GAIN_RST      = 16'd22938;

  // Folded value runs in signed Q5.15; two extra bits hold a reflection before saturation.
  localparam int X_W    = 21;
  localparam int XW_EXT = X_W + 2;
  localparam int FC_W   = $clog2(MAX_FOLDS + 1);

  localparam logic signed [XW_EXT-1:0] X_MAX_E = XW_EXT'(2**(X_W-1) - 1);
  localparam logic signed [XW_EXT-1:0] X_MIN_E = XW_EXT'(-(2**(X_W-1)));

  // Drive product and its rounding shift.
  localparam int DRV_P_W   = SAMPLE_BITS + DRV_GAIN_W + 1;
  localparam int DRV_SHIFT = SAMPLE_BITS - 8;
  localparam int DRV_HALF  = (2**DRV_SHIFT) / 2;

  // Wet fraction full scale, 1.0 in Q1.15.
  localparam int MIX_ONE_W = 17;
  localparam logic [MIX_ONE_W-1:0] MIX_ONE = 17'd32768;

  // Pipeline depth from an accepted transaction to its result strobe.
  localparam int IFD_LATENCY = MAX_FOLDS + 6;

  typedef struct packed {
    logic                          valid;
    logic                          bypass;
    logic signed [SAMPLE_BITS-1:0] dry;
    logic signed [X_W-1:0]         x;
    logic [FC_W-1:0]               rem;
  } cell_bus_t;

  function automatic logic signed [X_W-1:0] sat_x(input logic signed [XW_EXT-1:0] v);
    logic signed [XW_EXT-1:0] r;
    begin
      if (v > X_MAX_E) begin
        r = X_MAX_E;
      end else if (v < X_MIN_E) begin
        r = X_MIN_E;
      end else begin
        r = v;
      end
      return r[X_W-1:0];
    end
  endfunction

endpackage

[hdl/ifd_fold_cell.sv]
module ifd_fold_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ifd_pkg::THR_W-1:0]   thr,
  input  ifd_pkg::cell_bus_t          bus_i,
  output ifd_pkg::cell_bus_t          bus_o
);
  import ifd_pkg::*;

  logic signed [XW_EXT-1:0] x_e;
  logic signed [XW_EXT-1:0] t_e;
  logic signed [XW_EXT-1:0] fold_v;
  cell_bus_t                bus_nxt;
  cell_bus_t                bus_r;

  always_comb begin
    x_e    = XW_EXT'(bus_i.x);
    t_e    = $signed(XW_EXT'(thr));
    fold_v = x_e;
    // Once the value sits inside the band it stays there, so no stop flag is needed.
    if (bus_i.rem != '0) begin
      if (x_e > t_e) begin
        fold_v = (t_e <<< 1) - x_e;
      end else if (x_e < -t_e) begin
        fold_v = -(t_e <<< 1) - x_e;
      end
    end
    bus_nxt   = bus_i;
    bus_nxt.x = sat_x(fold_v);
    if (bus_i.rem != '0) begin
      bus_nxt.rem = bus_i.rem - FC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

[hdl/ifd_mix_out.sv]
module ifd_mix_out (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ifd_pkg::cell_bus_t                  bus_i,
  input  logic [ifd_pkg::WET_W-1:0]           wet_mix,
  input  logic [ifd_pkg::GAIN_W-1:0]          out_gain,
  output logic                                out_valid,
  output logic signed [ifd_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                out_clipped
);
  import ifd_pkg::*;

  localparam int WSHIFT    = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int DSHIFT    = (SAMPLE_BITS >= 16) ? 0 : 16 - SAMPLE_BITS;
  localparam int MIX_SHIFT = (SAMPLE_BITS >= 16) ? 15 : 31 - SAMPLE_BITS;
  localparam int PD_W      = SAMPLE_BITS + MIX_ONE_W + 1;
  localparam int PW_W      = X_W + MIX_ONE_W + 1;
  localparam int SUM_W     = ((PD_W + DSHIFT > PW_W + WSHIFT) ? PD_W + DSHIFT : PW_W + WSHIFT) + 1;
  localparam int Y_W       = SAMPLE_BITS + 6;
  localparam int G_W       = Y_W + GAIN_W + 1;
  localparam int R_W       = G_W + 1;

  localparam logic signed [SUM_W-1:0] MIX_HALF  = SUM_W'((2**MIX_SHIFT) / 2);
  localparam logic signed [R_W-1:0]   GAIN_HALF = R_W'(2**14);
  localparam logic signed [R_W-1:0]   SMAX_E    = R_W'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [R_W-1:0]   SMIN_E    = R_W'(-(2**(SAMPLE_BITS-1)));

  logic [MIX_ONE_W-1:0] m_sat;
  logic [MIX_ONE_W-1:0] d_frac;

  // Stage A: dry and wet products.
  logic                          a_valid_r, a_bypass_r;
  logic signed [SAMPLE_BITS-1:0] a_dry_r;
  logic signed [PD_W-1:0]        a_pd_r, a_pd_nxt;
  logic signed [PW_W-1:0]        a_pw_r, a_pw_nxt;
  // Stage B: rounded mix.
  logic                          b_valid_r, b_bypass_r;
  logic signed [SAMPLE_BITS-1:0] b_dry_r;
  logic signed [SUM_W-1:0]       b_sum;
  logic signed [Y_W-1:0]         b_y_r, b_y_nxt;
  // Stage C: output gain product.
  logic                          c_valid_r, c_bypass_r;
  logic signed [SAMPLE_BITS-1:0] c_dry_r;
  logic signed [G_W-1:0]         c_g_r, c_g_nxt;
  // Stage D: rounding, saturation, output register.
  logic signed [R_W-1:0]         d_res;
  logic signed [SAMPLE_BITS-1:0] d_sample_nxt, out_sample_r;
  logic                          d_clip_nxt, out_clip_r, out_valid_r;

  always_comb begin
    m_sat    = (wet_mix > WET_W'(MIX_ONE)) ? MIX_ONE : MIX_ONE_W'(wet_mix);
    d_frac   = MIX_ONE - m_sat;
    a_pd_nxt = PD_W'(bus_i.dry) * PD_W'($signed({1'b0, d_frac}));
    a_pw_nxt = PW_W'(bus_i.x) * PW_W'($signed({1'b0, m_sat}));
    b_sum    = (SUM_W'(a_pd_r) <<< DSHIFT) + (SUM_W'(a_pw_r) <<< WSHIFT) + MIX_HALF;
    b_y_nxt  = Y_W'(b_sum >>> MIX_SHIFT);
    c_g_nxt  = G_W'(b_y_r) * G_W'($signed({1'b0, out_gain}));
    d_res    = (R_W'(c_g_r) + GAIN_HALF) >>> 15;
    if (c_bypass_r) begin
      d_sample_nxt = c_dry_r;
      d_clip_nxt   = 1'b0;
    end else if (d_res > SMAX_E) begin
      d_sample_nxt = SMAX_E[SAMPLE_BITS-1:0];
      d_clip_nxt   = 1'b1;
    end else if (d_res < SMIN_E) begin
      d_sample_nxt = SMIN_E[SAMPLE_BITS-1:0];
      d_clip_nxt   = 1'b1;
    end else begin
      d_sample_nxt = d_res[SAMPLE_BITS-1:0];
      d_clip_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r    <= bus_i.valid;
      a_bypass_r   <= bus_i.bypass;
      a_dry_r      <= bus_i.dry;
      a_pd_r       <= a_pd_nxt;
      a_pw_r       <= a_pw_nxt;
      b_valid_r    <= a_valid_r;
      b_bypass_r   <= a_bypass_r;
      b_dry_r      <= a_dry_r;
      b_y_r        <= b_y_nxt;
      c_valid_r    <= b_valid_r;
      c_bypass_r   <= b_bypass_r;
      c_dry_r      <= b_dry_r;
      c_g_r        <= c_g_nxt;
      out_valid_r  <= c_valid_r;
      out_sample_r <= d_sample_nxt;
      out_clip_r   <= d_clip_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

endmodule

[hdl/iterative_foldback_distortion.sv]
// Foldback distortion waveshaper. A sample is taken at every clock edge where start is high
// (busy never rises, so one transaction can enter every cycle) and its result is on the
// out_ ports with out_valid for exactly one cycle, once it has passed the drive registers
// s0 and s1, the row of MAX_FOLDS fold cells and the mix stages A to D. The receiver cannot
// stall the block and must take every result in its strobe cycle. The pipeline holds
// MAX_FOLDS fold cells, one reflection per cell, plus two drive stages and four mix and
// output gain stages. Results leave in the order the samples came in. Configuration
// registers act on every stage directly, so they are to be written only when no transaction
// is in flight.
module iterative_foldback_distortion (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ifd_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic                                   in_bypass,
  output logic                                   out_valid,
  output logic signed [ifd_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_clipped,
  input  logic                                   cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ifd_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import ifd_pkg::*;

  logic [DRV_GAIN_W-1:0] drive_gain_r;
  logic [THR_W-1:0]      fold_threshold_r;
  logic [LIMIT_W-1:0]    fold_limit_r;
  logic [WET_W-1:0]      wet_mix_r;
  logic [GAIN_W-1:0]     out_gain_r;

  logic [FC_W-1:0]               limit_eff;
  logic                          s0_valid_r, s0_bypass_r;
  logic signed [SAMPLE_BITS-1:0] s0_dry_r;
  logic signed [DRV_P_W-1:0]     s0_prod_r, s0_prod_nxt;
  logic [FC_W-1:0]               s0_rem_r;
  logic signed [DRV_P_W:0]       drv_round;
  cell_bus_t                     s1_nxt, s1_r;
  cell_bus_t                     chain [MAX_FOLDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_gain_r     <= DRIVE_GAIN_RST;
      fold_threshold_r <= FOLD_THRESHOLD_RST;
      fold_limit_r     <= FOLD_LIMIT_RST;
      wet_mix_r        <= WET_MIX_RST;
      out_gain_r       <= OUT_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVE_GAIN:     drive_gain_r     <= cfg_wdata[DRV_GAIN_W-1:0];
        REG_FOLD_THRESHOLD: fold_threshold_r <= cfg_wdata[THR_W-1:0];
        REG_FOLD_LIMIT:     fold_limit_r     <= cfg_wdata[LIMIT_W-1:0];
        REG_WET_MIX:        wet_mix_r        <= cfg_wdata[WET_W-1:0];
        REG_OUT_GAIN:       out_gain_r       <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(fold_limit_r) > MAX_FOLDS) begin
      limit_eff = FC_W'(MAX_FOLDS);
    end else begin
      limit_eff = FC_W'(fold_limit_r);
    end
    s0_prod_nxt = DRV_P_W'(in_sample_in) * DRV_P_W'($signed({1'b0, drive_gain_r}));
    drv_round   = ((DRV_P_W+1)'(s0_prod_r) + (DRV_P_W+1)'(DRV_HALF)) >>> DRV_SHIFT;
    s1_nxt.valid  = s0_valid_r;
    s1_nxt.bypass = s0_bypass_r;
    s1_nxt.dry    = s0_dry_r;
    s1_nxt.x      = sat_x(XW_EXT'(drv_round));
    s1_nxt.rem    = s0_rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_r.valid  <= 1'b0;
    end else begin
      s0_valid_r  <= start;
      s0_bypass_r <= in_bypass;
      s0_dry_r    <= in_sample_in;
      s0_prod_r   <= s0_prod_nxt;
      s0_rem_r    <= limit_eff;
      s1_r        <= s1_nxt;
    end
  end

  assign chain[0] = s1_r;

  for (genvar i = 0; i < MAX_FOLDS; i++) begin : g_cell
    ifd_fold_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .thr   (fold_threshold_r),
      .bus_i (chain[i]),
      .bus_o (chain[i+1])
    );
  end

  ifd_mix_out u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .bus_i          (chain[MAX_FOLDS]),
    .wet_mix        (wet_mix_r),
    .out_gain       (out_gain_r),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

  assign busy = 1'b0;

endmodule

[hdl/ifd_checker.sv]
module ifd_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [ifd_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input logic                                   in_bypass,
  input logic                                   out_valid,
  input logic signed [ifd_pkg::SAMPLE_BITS-1:0] out_sample_out,
  input logic                                   out_clipped
);
  import ifd_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Every accepted transaction yields a result.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##IFD_LATENCY out_valid)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, IFD_LATENCY))
    else $error("result strobe without an accepted transaction");

  a_bypass_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_bypass) |-> ##IFD_LATENCY
      (out_sample_out == $past(in_sample_in, IFD_LATENCY) && !out_clipped))
    else $error("bypassed sample was altered");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> (out_sample_out == SMAX || out_sample_out == SMIN))
    else $error("clip flag set on a value that is not at full scale");

endmodule

bind iterative_foldback_distortion ifd_checker u_ifd_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ifd_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
  } shaped_t;

  localparam longint X_HI       = (longint'(1) << (X_W - 1)) - 1;
  localparam longint X_LO       = -(longint'(1) << (X_W - 1));
  localparam longint S_HI       = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint S_LO       = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam longint UNITY      = 32768;
  localparam longint HALF_Q15   = 16384;
  localparam int     DRIVE_FRAC = SAMPLE_BITS - 8;
  localparam longint HALF_DRIVE = longint'(1) << (DRIVE_FRAC - 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_OUT_GAIN + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic in_bypass = 1'b0;
  logic out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic out_clipped;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register image kept in step with every write to the block.
  logic [DRV_GAIN_W-1:0] cur_drive = DRIVE_GAIN_RST;
  logic [THR_W-1:0]      cur_level = FOLD_THRESHOLD_RST;
  logic [LIMIT_W-1:0]    cur_folds = FOLD_LIMIT_RST;
  logic [WET_W-1:0]      cur_wet   = WET_MIX_RST;
  logic [GAIN_W-1:0]     cur_gain  = OUT_GAIN_RST;

  shaped_t expected_shapes[$];
  shaped_t oldest_shape;
  int mismatch_count = 0;
  int sender_idle_pct = 23;

  iterative_foldback_distortion uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_sample_in(in_sample_in),
    .in_bypass(in_bypass),
    .out_valid(out_valid),
    .out_sample_out(out_sample_out),
    .out_clipped(out_clipped),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_x(input longint v);
    return (v > X_HI) ? X_HI : ((v < X_LO) ? X_LO : v);
  endfunction

  function automatic shaped_t shape_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic byp);
    shaped_t r;
    longint s, d, t, w, g, x, m, y, v;
    int folds;
    bit settled;
    s = smp;
    d = cur_drive;
    t = cur_level;
    w = cur_wet;
    g = cur_gain;
    r.sample = smp;
    r.clipped = 1'b0;
    if (!byp) begin
      x = clamp_x((s * d + HALF_DRIVE) >>> DRIVE_FRAC);
      folds = (cur_folds > MAX_FOLDS) ? MAX_FOLDS : cur_folds;
      settled = 1'b0;
      // Reflect about the nearer threshold until the value is inside the band or the folds run out.
      for (int i = 0; i < folds && !settled; i++) begin
        if (x > t) begin
          x = clamp_x(2 * t - x);
        end else if (x < -t) begin
          x = clamp_x(-2 * t - x);
        end else begin
          settled = 1'b1;
        end
      end
      m = (w > UNITY) ? UNITY : w;
      y = (s * (UNITY - m) + x * m + HALF_Q15) >>> 15;
      v = (y * g + HALF_Q15) >>> 15;
      if (v > S_HI) begin
        v = S_HI;
        r.clipped = 1'b1;
      end else if (v < S_LO) begin
        v = S_LO;
        r.clipped = 1'b1;
      end
      r.sample = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_shapes.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        oldest_shape = expected_shapes.pop_front();
        if (out_sample_out !== oldest_shape.sample) begin
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    out_sample_out, oldest_shape.sample));
        end
        if (out_clipped !== oldest_shape.clipped) begin
          report_mismatch($sformatf("clipped %b, expected %b",
                                    out_clipped, oldest_shape.clipped));
        end
      end
    end
  end

  // Leaves start high on return so back-to-back transactions need no gap.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic byp);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_sample_in <= smp;
    in_bypass <= byp;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    expected_shapes.push_back(shape_sample(smp, byp));
  endtask

  task automatic settle_pipeline();
    start <= 1'b0;
    while (expected_shapes.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_DRIVE_GAIN:     cur_drive = value[DRV_GAIN_W-1:0];
      REG_FOLD_THRESHOLD: cur_level = value[THR_W-1:0];
      REG_FOLD_LIMIT:     cur_folds = value[LIMIT_W-1:0];
      REG_WET_MIX:        cur_wet = value[WET_W-1:0];
      REG_OUT_GAIN:       cur_gain = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register, plus one unmapped index that must change nothing.
  task automatic program_registers(input logic [CFG_DATA_W-1:0] drive,
                                   input logic [CFG_DATA_W-1:0] level,
                                   input logic [CFG_DATA_W-1:0] folds,
                                   input logic [CFG_DATA_W-1:0] wet,
                                   input logic [CFG_DATA_W-1:0] gain);
    write_register(REG_DRIVE_GAIN, drive);
    write_register(REG_FOLD_THRESHOLD, level);
    write_register(REG_FOLD_LIMIT, folds);
    write_register(REG_WET_MIX, wet);
    write_register(REG_OUT_GAIN, gain);
    write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                   CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_setting(input int lo, input int hi);
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 7) begin
      return CFG_DATA_W'($urandom_range(hi, lo));
    end else if (pick == 7) begin
      return CFG_DATA_W'(lo);
    end else if (pick == 8) begin
      return CFG_DATA_W'(hi);
    end
    return CFG_DATA_W'($urandom);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      return SAMPLE_BITS'($urandom);
    end else if (pick < 85) begin
      return SAMPLE_BITS'(int'($urandom_range(8191, 0)) - 4096);
    end else if (pick < 92) begin
      return S_HI[SAMPLE_BITS-1:0];
    end
    return S_LO[SAMPLE_BITS-1:0];
  endfunction

  task automatic test_reset_defaults();
    send_sample(S_HI[SAMPLE_BITS-1:0], 1'b0);
    send_sample(S_LO[SAMPLE_BITS-1:0], 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd16384, 1'b0);
    send_sample(S_HI[SAMPLE_BITS-1:0], 1'b1);
    send_sample(S_LO[SAMPLE_BITS-1:0], 1'b1);
  endtask

  task automatic test_fold_corners();
    // Zero threshold, fold limit above the cap, wet mix above full scale,
    // all upper data bits set.
    settle_pipeline();
    program_registers(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(S_HI[SAMPLE_BITS-1:0], 1'b0);
    send_sample(S_LO[SAMPLE_BITS-1:0], 1'b0);
    send_sample(16'sd300, 1'b0);
    // No folding at all, fully dry, zero output gain.
    settle_pipeline();
    program_registers(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_sample(S_HI[SAMPLE_BITS-1:0], 1'b0);
    send_sample(S_LO[SAMPLE_BITS-1:0], 1'b0);
    // Largest random-range drive into the smallest random-range threshold, with the full fold count.
    settle_pipeline();
    program_registers(16'd5120, 16'd3277, 16'd10, 16'd16384, 16'd49152);
    send_sample(S_HI[SAMPLE_BITS-1:0], 1'b0);
    send_sample(S_LO[SAMPLE_BITS-1:0], 1'b0);
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd7, 1'b0);
    // Unity drive, full-scale threshold, a single fold.
    settle_pipeline();
    program_registers(16'd256, 16'd32768, 16'd1, 16'd32768, 16'd32768);
    send_sample(S_HI[SAMPLE_BITS-1:0], 1'b0);
    send_sample(S_LO[SAMPLE_BITS-1:0], 1'b0);
    send_sample(16'sd1, 1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int setups, input int per_setup);
    sender_idle_pct = idle_pct;
    repeat (setups) begin
      settle_pipeline();
      program_registers(rand_setting(256, 5120), rand_setting(3277, 32768),
                        rand_setting(1, 10), rand_setting(0, 32768),
                        rand_setting(0, 49152));
      repeat (per_setup) begin
        send_sample(rand_sample(), $urandom_range(9, 0) == 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_fold_corners();
    test_random_traffic(23, 6, 106);
    test_random_traffic(45, 6, 106);
    test_random_traffic(0, 6, 106);
    settle_pipeline();
    repeat (IFD_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

[sim.f]
hdl/ifd_pkg.sv
hdl/ifd_fold_cell.sv
hdl/ifd_mix_out.sv
hdl/iterative_foldback_distortion.sv
hdl/ifd_checker.sv
verif/tb_top.sv
